/* hdl/msbm_pkg.sv */
// Shared types and constants for the multi-signature byte matcher.
// No dependencies; every other file in this folder imports it.
`default_nettype none

package msbm_pkg;

  // Input field widths
  localparam int FuncW      = 2;
  localparam int SlotFieldW = 3;
  localparam int PosFieldW  = 5;
  localparam int LenFieldW  = 6;
  localparam int ByteW      = 8;
  localparam int CfgW       = 4;

  // Result field widths
  localparam int MatchSigW  = 3;
  localparam int OffsetOutW = 24;

  // Results per scanned byte are capped at this count
  localparam int MaxResults = 8;
  localparam int ResCntW    = $clog2(MaxResults);

  typedef enum logic [FuncW-1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_SCAN    = 2'd1,
    FUNC_RESTART = 2'd2
  } func_t;

  // Signature byte/length write request broadcast to every slot
  typedef struct packed {
    logic                  valid;
    logic [SlotFieldW-1:0] slot;
    logic [PosFieldW-1:0]  pos;
    logic [LenFieldW-1:0]  len;
    logic [ByteW-1:0]      data;
  } sig_load_t;

  // History byte handed from slot to slot during a compare sweep
  typedef struct packed {
    logic             valid;
    logic             tail;
    logic [ByteW-1:0] data;
  } feed_t;

endpackage

`default_nettype wire

/* hdl/multi_signature_byte_matcher_core.sv */
// Multi-signature byte matcher. Load, restart and unused items leave the core idle.
// A scan runs in steps: the window rotates once through the slot chain (MAX_SIG_LEN bytes),
// the last byte drains through the NUM_SIGS slots, then the sweep hands off to the result sequencer.
// Results then come one per cycle while the output does not stall, lowest slot first.
// Next item is taken while the last result still waits. Sync reset clears the control state,
// history window, fill and slot lengths, but not the signature store.
`default_nettype none

module multi_signature_byte_matcher_core
  import msbm_pkg::*;
#(
  parameter int NUM_SIGS    = 8,
  parameter int MAX_SIG_LEN = 32,
  parameter int OFFSET_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FuncW-1:0]      func,
  input  logic [SlotFieldW-1:0] sig_index,
  input  logic [PosFieldW-1:0]  sig_pos,
  input  logic [LenFieldW-1:0]  sig_len,
  input  logic [ByteW-1:0]      data_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [MatchSigW-1:0]  match_sig,
  output logic [OffsetOutW-1:0] match_offset,
  output logic [LenFieldW-1:0]  match_len,
  output logic                  last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CfgW-1:0]       cfg_data
);

  localparam int FillW = $clog2(MAX_SIG_LEN + 1);
  localparam int AddrW = (MAX_SIG_LEN > 1) ? $clog2(MAX_SIG_LEN) : 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SWEEP = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_HAND  = 4'b1000
  } state_t;

  state_t                             state;
  state_t                             state_next;
  logic [ByteW-1:0]                   win [MAX_SIG_LEN];
  logic [FillW-1:0]                   fill;
  logic [OFFSET_BITS-1:0]             bytes_seen;
  logic [OFFSET_BITS-1:0]             cur;
  logic [AddrW-1:0]                   j;
  logic [CfgW-1:0]                    active_sigs;
  logic                               in_accept;
  logic                               do_scan;
  logic                               do_restart;
  logic                               rotate;
  logic                               tail;
  logic                               emit_busy;
  sig_load_t                          load;
  feed_t                              chain [NUM_SIGS+1];
  logic [NUM_SIGS-1:0]                hits;
  logic [NUM_SIGS-1:0]                act_mask;
  logic [NUM_SIGS-1:0][LenFieldW-1:0] lens;

  assign in_stall   = !((state == ST_IDLE) && !emit_busy);
  assign in_accept  = in_valid && !in_stall;
  assign do_scan    = in_accept && (func_t'(func) == FUNC_SCAN);
  assign do_restart = in_accept && (func_t'(func) == FUNC_RESTART);
  assign rotate     = (state == ST_SWEEP);
  assign tail       = (j == AddrW'(MAX_SIG_LEN - 1));
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_sigs <= '0;
    end else if (cfg_valid && cfg_ready) begin
      active_sigs <= cfg_data;
    end
  end

  assign load.valid = in_accept && (func_t'(func) == FUNC_LOAD);
  assign load.slot  = sig_index;
  assign load.pos   = sig_pos;
  assign load.len   = sig_len;
  assign load.data  = data_byte;

  // History window: newest byte at index 0; a sweep rotates it one full turn
  for (genvar p = 0; p < MAX_SIG_LEN; p++) begin : g_win
    always_ff @(posedge clk) begin
      if (rst || do_restart) begin
        win[p] <= '0;
      end else if (do_scan) begin
        if (p == 0) begin
          win[p] <= data_byte;
        end else begin
          win[p] <= win[(p + MAX_SIG_LEN - 1) % MAX_SIG_LEN];
        end
      end else if (rotate) begin
        win[p] <= win[(p + 1) % MAX_SIG_LEN];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || do_restart) begin
      fill       <= '0;
      bytes_seen <= '0;
    end else if (do_scan) begin
      if (fill != FillW'(MAX_SIG_LEN)) begin
        fill <= fill + FillW'(1);
      end
      if (bytes_seen != '1) begin
        bytes_seen <= bytes_seen + OFFSET_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_scan) begin
      cur <= bytes_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j <= '0;
    end else if (rotate) begin
      j <= tail ? '0 : j + AddrW'(1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (do_scan) begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (tail) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // hold until the final history byte has passed the last slot
        if (chain[NUM_SIGS].valid && chain[NUM_SIGS].tail) begin
          state_next = ST_HAND;
        end
      end
      ST_HAND: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign chain[0].valid = rotate;
  assign chain[0].tail  = tail;
  assign chain[0].data  = win[0];

  for (genvar s = 0; s < NUM_SIGS; s++) begin : g_slot
    assign act_mask[s] = s < int'(active_sigs);

    msbm_slot #(
      .SLOT        (s),
      .MAX_SIG_LEN (MAX_SIG_LEN),
      .FILL_W      (FillW)
    ) u_slot (
      .clk      (clk),
      .rst      (rst),
      .load     (load),
      .fill     (fill),
      .feed_in  (chain[s]),
      .feed_out (chain[s+1]),
      .slot_len (lens[s]),
      .hit      (hits[s])
    );
  end

  msbm_emit #(
    .NUM_SIGS    (NUM_SIGS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .start        (state == ST_HAND),
    .hits         (hits & act_mask),
    .cur          (cur),
    .lens         (lens),
    .busy         (emit_busy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .match_sig    (match_sig),
    .match_offset (match_offset),
    .match_len    (match_len),
    .last         (last)
  );

  a_tail_in_drain: assert property (@(posedge clk) disable iff (rst)
    (chain[NUM_SIGS].valid && chain[NUM_SIGS].tail) |-> (state == ST_DRAIN))
    else $error("sweep tail reached chain end outside drain");

  a_hand_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HAND) |-> !emit_busy)
    else $error("result sequencer busy at hand-off");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FillW'(MAX_SIG_LEN))
    else $error("history fill above window depth");

  a_scan_holds: assert property (@(posedge clk) disable iff (rst)
    do_scan |=> (in_stall && (state == ST_SWEEP)))
    else $error("scan request did not start a sweep");

endmodule

`default_nettype wire

/* hdl/msbm_slot.sv */
// One signature slot of the compare chain: signature store, length and match flag.
// Depends on msbm_pkg for the load request and the chain feed types.
`default_nettype none

module msbm_slot
  import msbm_pkg::*;
#(
  parameter int SLOT        = 0,
  parameter int MAX_SIG_LEN = 32,
  parameter int FILL_W      = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sig_load_t            load,
  input  logic [FILL_W-1:0]    fill,
  input  feed_t                feed_in,
  output feed_t                feed_out,
  output logic [LenFieldW-1:0] slot_len,
  output logic                 hit
);

  localparam int AddrW = (MAX_SIG_LEN > 1) ? $clog2(MAX_SIG_LEN) : 1;
  localparam int CmpW  = (FILL_W > LenFieldW) ? FILL_W : LenFieldW;

  logic [ByteW-1:0]     sig_mem [MAX_SIG_LEN];
  logic [ByteW-1:0]     rd_data;
  logic [AddrW-1:0]     cnt;
  logic [AddrW-1:0]     cnt_a;
  feed_t                stage;
  logic [LenFieldW-1:0] len;
  logic [LenFieldW-1:0] len_sat;
  logic                 match;
  logic                 match_next;
  logic                 load_hit;
  logic                 pos_ok;
  logic [AddrW-1:0]     wr_addr;
  logic [AddrW-1:0]     rd_addr;
  logic                 init;
  logic                 base;
  logic                 in_range;

  assign load_hit = load.valid && (int'(load.slot) == SLOT);
  assign pos_ok   = int'(load.pos) < MAX_SIG_LEN;
  assign wr_addr  = AddrW'(load.pos);
  assign len_sat  = (int'(load.len) > MAX_SIG_LEN) ? LenFieldW'(MAX_SIG_LEN) : load.len;

  // Signature byte k is compared against history byte len-1-k
  assign rd_addr  = AddrW'(CmpW'(len) - CmpW'(cnt) - CmpW'(1));

  always_ff @(posedge clk) begin
    if (load_hit && pos_ok) begin
      sig_mem[wr_addr] <= load.data;
    end
    if (feed_in.valid) begin
      rd_data <= sig_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (load_hit) begin
      len <= len_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
      cnt         <= '0;
    end else begin
      stage.valid <= feed_in.valid;
      if (feed_in.valid) begin
        cnt <= feed_in.tail ? '0 : cnt + AddrW'(1);
      end
    end
    if (feed_in.valid) begin
      stage.tail <= feed_in.tail;
      stage.data <= feed_in.data;
      cnt_a      <= cnt;
    end
  end

  // First history byte of a sweep restarts the flag from the length check
  assign init     = (len != '0) && (CmpW'(len) <= CmpW'(fill));
  assign base     = (cnt_a == '0) ? init : match;
  assign in_range = CmpW'(cnt_a) < CmpW'(len);

  always_comb begin
    match_next = match;
    if (stage.valid) begin
      match_next = in_range ? (base && (rd_data == stage.data)) : base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else begin
      match <= match_next;
    end
  end

  assign feed_out = stage;
  assign slot_len = len;
  assign hit      = match;

endmodule

`default_nettype wire

/* hdl/msbm_emit.sv */
// Result sequencer: walks the hit vector lowest slot first and fills the output register.
// Depends on msbm_pkg for result widths and the per-byte result cap.
`default_nettype none

module msbm_emit
  import msbm_pkg::*;
#(
  parameter int NUM_SIGS    = 8,
  parameter int OFFSET_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [NUM_SIGS-1:0]                 hits,
  input  logic [OFFSET_BITS-1:0]              cur,
  input  logic [NUM_SIGS-1:0][LenFieldW-1:0]  lens,
  output logic                                busy,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [MatchSigW-1:0]                match_sig,
  output logic [OffsetOutW-1:0]               match_offset,
  output logic [LenFieldW-1:0]                match_len,
  output logic                                last
);

  localparam int SelW     = (NUM_SIGS > 1) ? $clog2(NUM_SIGS) : 1;
  localparam int OffCalcW = (OFFSET_BITS + 1 > OffsetOutW) ? OFFSET_BITS + 1 : OffsetOutW;

  logic [NUM_SIGS-1:0]    vec;
  logic [NUM_SIGS-1:0]    rest;
  logic [OFFSET_BITS-1:0] cur_reg;
  logic [ResCntW-1:0]     cnt;
  logic [SelW-1:0]        sel;
  logic                   last_res;
  logic                   advance;
  logic [OffCalcW-1:0]    off_full;

  always_comb begin
    sel = '0;
    for (int i = NUM_SIGS - 1; i >= 0; i--) begin
      if (vec[i]) begin
        sel = SelW'(i);
      end
    end
  end

  assign rest     = vec & ~(NUM_SIGS'(1) << sel);
  assign last_res = (rest == '0) || (cnt == ResCntW'(MaxResults - 1));
  assign advance  = busy && (!out_valid || !out_stall);
  assign off_full = OffCalcW'(cur_reg) + OffCalcW'(1) - OffCalcW'(lens[sel]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (start) begin
        busy <= |hits;
        cnt  <= '0;
      end else if (advance) begin
        if (last_res) begin
          busy <= 1'b0;
          cnt  <= '0;
        end else begin
          cnt <= cnt + ResCntW'(1);
        end
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      vec     <= hits;
      cur_reg <= cur;
    end else if (advance) begin
      vec <= rest;
    end
    if (advance) begin
      match_sig    <= MatchSigW'(sel);
      match_offset <= off_full[OffsetOutW-1:0];
      match_len    <= lens[sel];
      last         <= last_res;
    end
  end

endmodule

`default_nettype wire
